@@ rtl/rtd_pkg.sv @@
// Shared types, constants and the PT100 table for the RTD bridge temperature core.
package rtd_pkg;

  localparam int TABLE_ENTRIES = 151;
  localparam int INDEX_CAP     = TABLE_ENTRIES - 2;
  localparam int R_FRAC        = 8;
  localparam int R_BITS        = 25;
  localparam int SEARCH_STEPS  = 8;

  typedef enum logic [1:0] {
    REG_BRIDGE_OHMS   = 2'd0,
    REG_LOWEST_INDEX  = 2'd1,
    REG_HIGHEST_INDEX = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic        bad;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [14:0] den;
    logic [38:0] num;
    logic [24:0] r;
    logic [24:0] rem;
    logic [23:0] span;
    logic [15:0] frac;
  } item_t;

  localparam logic [15:0] PT100_ROM [0:TABLE_ENTRIES-1] = '{
    16'd10000, 16'd10039, 16'd10078, 16'd10117, 16'd10156, 16'd10195, 16'd10234, 16'd10273,
    16'd10312, 16'd10351, 16'd10390, 16'd10429, 16'd10468, 16'd10507, 16'd10546, 16'd10585,
    16'd10624, 16'd10663, 16'd10702, 16'd10740, 16'd10779, 16'd10818, 16'd10857, 16'd10896,
    16'd10935, 16'd10973, 16'd11012, 16'd11051, 16'd11090, 16'd11129, 16'd11167, 16'd11206,
    16'd11245, 16'd11283, 16'd11322, 16'd11361, 16'd11400, 16'd11438, 16'd11477, 16'd11515,
    16'd11554, 16'd11593, 16'd11631, 16'd11670, 16'd11708, 16'd11747, 16'd11786, 16'd11824,
    16'd11863, 16'd11901, 16'd11940, 16'd11978, 16'd12017, 16'd12055, 16'd12094, 16'd12132,
    16'd12171, 16'd12209, 16'd12247, 16'd12286, 16'd12324, 16'd12363, 16'd12401, 16'd12439,
    16'd12478, 16'd12516, 16'd12554, 16'd12593, 16'd12631, 16'd12669, 16'd12708, 16'd12746,
    16'd12784, 16'd12822, 16'd12861, 16'd12899, 16'd12937, 16'd12975, 16'd13013, 16'd13052,
    16'd13090, 16'd13128, 16'd13166, 16'd13204, 16'd13242, 16'd13280, 16'd13318, 16'd13357,
    16'd13395, 16'd13433, 16'd13471, 16'd13509, 16'd13547, 16'd13585, 16'd13623, 16'd13661,
    16'd13699, 16'd13737, 16'd13775, 16'd13813, 16'd13851, 16'd13888, 16'd13926, 16'd13964,
    16'd14002, 16'd14040, 16'd14078, 16'd14116, 16'd14154, 16'd14191, 16'd14229, 16'd14267,
    16'd14305, 16'd14343, 16'd14380, 16'd14418, 16'd14456, 16'd14494, 16'd14531, 16'd14569,
    16'd14607, 16'd14644, 16'd14682, 16'd14720, 16'd14757, 16'd14795, 16'd14833, 16'd14870,
    16'd14908, 16'd14946, 16'd14983, 16'd15021, 16'd15058, 16'd15096, 16'd15133, 16'd15171,
    16'd15208, 16'd15246, 16'd15283, 16'd15321, 16'd15358, 16'd15396, 16'd15433, 16'd15471,
    16'd15508, 16'd15546, 16'd15583, 16'd15620, 16'd15658, 16'd15695, 16'd15733
  };

  function automatic logic [23:0] rom_at(input logic [7:0] idx);
    logic [7:0] i;
    i = (idx > 8'(TABLE_ENTRIES - 1)) ? 8'(TABLE_ENTRIES - 1) : idx;
    return {PT100_ROM[i], 8'b0};
  endfunction

  function automatic logic [7:0] cap_index(input logic [7:0] idx);
    return (idx > 8'(INDEX_CAP)) ? 8'(INDEX_CAP) : idx;
  endfunction

endpackage

@@ rtl/rtd_bridge_temperature_core.sv @@
// Top level: PT100 bridge resistance, table search and interpolation pipeline.
// Throughput: one word per cycle; every stage is a register, stalls freeze all stages.
// The pipeline holds 25 divider stages for R, 8 search stages and FRACTION_BITS interpolation stages.
// Reset (rst, synchronous): clears all valid bits, registers return to 220 ohms, 0, 149.
module rtd_bridge_temperature_core import rtd_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] sensor_average,
  input  logic [13:0] supply_average,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] temperature_q8,
  output logic        out_of_range
);

  localparam int S_PREP  = 1;
  localparam int S_MUL   = 2;
  localparam int S_DIV0  = 3;
  localparam int S_RANGE = S_DIV0 + R_BITS;
  localparam int S_SRCH0 = S_RANGE + 1;
  localparam int S_BASE  = S_SRCH0 + SEARCH_STEPS;
  localparam int S_FR0   = S_BASE + 1;
  localparam int NST     = S_FR0 + FRACTION_BITS - 1;
  localparam int TW      = 8 + FRACTION_BITS;

  logic [16:0] ohms100;
  logic [7:0]  lowest_index;
  logic [7:0]  highest_index;

  item_t st  [1:NST];
  item_t nxt [1:NST];
  logic  vld [0:NST];
  logic  adv;

  logic [TW-1:0] temp_full;
  logic [15:0]   temp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ohms100       <= 17'd22000;
      lowest_index  <= 8'd0;
      highest_index <= 8'd149;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_BRIDGE_OHMS:   ohms100 <= 17'(cfg_data * 17'd100);
        REG_LOWEST_INDEX:  lowest_index <= cfg_data[7:0];
        REG_HIGHEST_INDEX: highest_index <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign vld[0]   = in_valid;

  genvar i;
  generate
    for (i = 1; i <= NST; i++) begin : g_stage
      if (i == S_PREP) begin : g_prep
        always_comb begin
          nxt[i]     = '0;
          nxt[i].bad = (supply_average == 14'd0 && sensor_average == 14'd0) ||
                       (sensor_average > supply_average);
          nxt[i].den = 15'(supply_average) + 15'(sensor_average);
          nxt[i].num = 39'(supply_average - sensor_average);
          nxt[i].lo  = cap_index(lowest_index);
          nxt[i].hi  = cap_index(highest_index);
        end
      end else if (i == S_MUL) begin : g_mul
        logic [30:0] prod;
        always_comb begin
          prod       = 31'(ohms100 * st[i-1].num[13:0]);
          nxt[i]     = st[i-1];
          nxt[i].rem = 25'(prod[30:17]);
          nxt[i].num = {prod[16:0], 22'b0};
          nxt[i].r   = '0;
        end
      end else if (i < S_RANGE) begin : g_div
        logic [15:0] t;
        logic        ge;
        always_comb begin
          t          = {st[i-1].rem[14:0], st[i-1].num[38]};
          ge         = t >= {1'b0, st[i-1].den};
          nxt[i]     = st[i-1];
          nxt[i].rem = 25'(ge ? t - {1'b0, st[i-1].den} : t);
          nxt[i].num = {st[i-1].num[37:0], 1'b0};
          nxt[i].r   = {st[i-1].r[23:0], ge};
        end
      end else if (i == S_RANGE) begin : g_range
        always_comb begin
          nxt[i]     = st[i-1];
          nxt[i].bad = st[i-1].bad ||
                       (st[i-1].r > 25'(rom_at(st[i-1].hi))) ||
                       (st[i-1].r < 25'(rom_at(st[i-1].lo)));
        end
      end else if (i < S_BASE) begin : g_srch
        logic [7:0] mid;
        always_comb begin
          mid    = 8'((9'(st[i-1].lo) + 9'(st[i-1].hi) + 9'd1) >> 1);
          nxt[i] = st[i-1];
          if (st[i-1].lo < st[i-1].hi) begin
            if (25'(rom_at(mid)) <= st[i-1].r) begin
              nxt[i].lo = mid;
            end else begin
              nxt[i].hi = mid - 8'd1;
            end
          end
        end
      end else if (i == S_BASE) begin : g_base
        logic [23:0] base;
        always_comb begin
          base        = rom_at(st[i-1].lo);
          nxt[i]      = st[i-1];
          nxt[i].span = rom_at(st[i-1].lo + 8'd1) - base;
          nxt[i].rem  = st[i-1].r - 25'(base);
          nxt[i].frac = '0;
        end
      end else begin : g_frac
        logic [24:0] t;
        logic        ge;
        always_comb begin
          t           = {st[i-1].rem[23:0], 1'b0};
          ge          = t >= {1'b0, st[i-1].span};
          nxt[i]      = st[i-1];
          nxt[i].rem  = ge ? t - {1'b0, st[i-1].span} : t;
          nxt[i].frac = {st[i-1].frac[14:0], ge};
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (adv) begin
          vld[i] <= vld[i-1];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          st[i] <= nxt[i];
        end
      end
    end
  endgenerate

  always_comb begin
    temp_full = (TW'(st[NST].lo) << FRACTION_BITS) +
                ((st[NST].span == 24'd0) ? TW'(0) : TW'(st[NST].frac[FRACTION_BITS-1:0]));
    temp_next = (temp_full > TW'(17'h0FFFF)) ? 16'hFFFF : 16'(temp_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_of_range   <= st[NST].bad;
      temperature_q8 <= st[NST].bad ? 16'd0 : temp_next;
    end
  end

`ifndef SYNTHESIS
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> temperature_q8 == 16'd0)
    else $error("out_of_range word carries nonzero temperature");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vld[NST] && out_valid && !out_ready |=> vld[NST] && out_valid)
    else $error("pipeline word lost during stall");
`endif

endmodule
